[rtl/tdpt_pkg.sv]
// Shared types and constants for the trial division prime test block.
package tdpt_pkg;

   localparam int NUMBER_WIDTH = 16;
   localparam int CNT_WIDTH    = $clog2(NUMBER_WIDTH);
   // One bit above the doubled width so that the square of the divisor after the
   // last useful one still compares correctly at the widest candidate.
   localparam int SQ_WIDTH     = 2 * NUMBER_WIDTH + 1;
   localparam int TDATA_WIDTH  = ((NUMBER_WIDTH + 7) / 8) * 8;

   localparam logic [NUMBER_WIDTH-1:0] FIRST_DIVISOR = NUMBER_WIDTH'(2);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEST,
      ST_DIVIDE,
      ST_EVAL,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic div_start;
      logic div_step;
      logic next_div;
      logic out_load;
      logic out_prime;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic below_two;
      logic sq_over;
      logic rem_zero;
      logic div_last;
   } status_type;

endpackage

[rtl/tdpt_dpath.sv]
// Datapath: candidate, trial divisor with its square, bit-serial remainder and result register.
module tdpt_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tdpt_pkg::cmd_type                    cmd,
   input  logic [tdpt_pkg::NUMBER_WIDTH-1:0]    candidate,
   output tdpt_pkg::status_type                 status,
   output logic [tdpt_pkg::NUMBER_WIDTH-1:0]    number_out,
   output logic                                 is_prime
);
   import tdpt_pkg::*;

   logic [NUMBER_WIDTH-1:0] cand_ff, cand_in;
   logic [NUMBER_WIDTH-1:0] div_ff, div_in;
   logic [SQ_WIDTH-1:0]     sq_ff, sq_in;
   logic [NUMBER_WIDTH-1:0] rem_ff, rem_in;
   logic [CNT_WIDTH-1:0]    cnt_ff, cnt_in;
   logic [NUMBER_WIDTH-1:0] num_out_ff, num_out_in;
   logic                    prime_out_ff, prime_out_in;

   logic [NUMBER_WIDTH:0]   shifted;
   logic [NUMBER_WIDTH:0]   diff;
   logic [NUMBER_WIDTH:0]   sq_step;

   always_comb begin
      shifted = {rem_ff, cand_ff[cnt_ff]};
      diff    = shifted - {1'b0, div_ff};
      // (d+1)^2 = d^2 + 2d + 1
      sq_step = {div_ff, 1'b1};

      cand_in      = cand_ff;
      div_in       = div_ff;
      sq_in        = sq_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      num_out_in   = num_out_ff;
      prime_out_in = prime_out_ff;

      if (cmd.load) begin
         cand_in = candidate;
         div_in  = FIRST_DIVISOR;
         sq_in   = SQ_WIDTH'(FIRST_DIVISOR) * SQ_WIDTH'(FIRST_DIVISOR);
      end
      if (cmd.next_div) begin
         div_in = div_ff + NUMBER_WIDTH'(1);
         sq_in  = sq_ff + SQ_WIDTH'(sq_step);
      end
      if (cmd.div_start) begin
         rem_in = '0;
         cnt_in = CNT_WIDTH'(NUMBER_WIDTH - 1);
      end
      if (cmd.div_step) begin
         // Restoring step: the partial remainder stays below the divisor.
         if (!diff[NUMBER_WIDTH]) begin
            rem_in = diff[NUMBER_WIDTH-1:0];
         end else begin
            rem_in = shifted[NUMBER_WIDTH-1:0];
         end
         cnt_in = cnt_ff - CNT_WIDTH'(1);
      end
      if (cmd.out_load) begin
         num_out_in   = cand_ff;
         prime_out_in = cmd.out_prime;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff <= FIRST_DIVISOR;
         sq_ff  <= SQ_WIDTH'(FIRST_DIVISOR) * SQ_WIDTH'(FIRST_DIVISOR);
      end else begin
         div_ff <= div_in;
         sq_ff  <= sq_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff      <= cand_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      num_out_ff   <= num_out_in;
      prime_out_ff <= prime_out_in;
   end

   assign status.below_two = (cand_ff < FIRST_DIVISOR);
   assign status.sq_over   = (sq_ff > SQ_WIDTH'(cand_ff));
   assign status.rem_zero  = (rem_ff == '0);
   assign status.div_last  = (cnt_ff == '0);

   assign number_out = num_out_ff;
   assign is_prime   = prime_out_ff;

   a_sq_tracks: assert property (@(posedge clock) disable iff (reset)
      sq_ff == SQ_WIDTH'(div_ff) * SQ_WIDTH'(div_ff))
      else $error("divisor square out of step with divisor");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |=> rem_ff < div_ff)
      else $error("partial remainder not below divisor");

endmodule

[rtl/tdpt_ctrl.sv]
// Controller state machine sequencing the divisor search and the result handshake.
module tdpt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  tdpt_pkg::status_type status,
   output tdpt_pkg::cmd_type    cmd
);
   import tdpt_pkg::*;

   state_type state_ff, state_in;
   logic      verdict_ff, verdict_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_fire;
   logic      slot_free;

   assign req_fire  = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in   = state_ff;
      verdict_in = verdict_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_TEST;
         end
         ST_TEST: begin
            if (status.below_two) begin
               verdict_in = 1'b0;
               state_in   = ST_DONE;
            end else if (status.sq_over) begin
               verdict_in = 1'b1;
               state_in   = ST_DONE;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_last) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (status.rem_zero) begin
               verdict_in = 1'b0;
               state_in   = ST_DONE;
            end else begin
               state_in = ST_TEST;
            end
         end
         ST_DONE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      cmd           = '0;
      cmd.out_prime = verdict_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_TEST: begin
            cmd.div_start = !status.below_two && !status.sq_over;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_EVAL: begin
            cmd.next_div = !status.rem_zero;
         end
         ST_DONE: begin
            cmd.out_load = slot_free;
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_tready);
   assign rsp_tvalid   = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_TEST)
      else $error("accepted item did not start a search");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(cmd.out_load && rsp_valid_ff && !rsp_tready))
      else $error("result register overwritten while still pending");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("loaded result not presented");

endmodule

[rtl/trial_division_prime_test.sv]
// Top level of the trial division prime test: controller and datapath.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_tvalid/tready    | tdata: candidate
//   rsp     | out | rsp_tvalid/tready    | tdata: number_out, tuser: is_prime
//
// An item takes setup and then, for every divisor tried, a test, a bit-serial division
// and an evaluation, up to about sqrt(candidate) divisors; the bit-serial remainder unit
// works one bit per cycle. A candidate below 2, 2 or 3 finishes without any division.
// Reset is synchronous and active high and clears the controller and the result valid.
// The result register lets a new item be accepted while the previous result waits;
// a finished search holds until that register is free.
module trial_division_prime_test (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tdpt_pkg::TDATA_WIDTH-1:0] req_tdata,  // [NUMBER_WIDTH-1:0] candidate
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tdpt_pkg::TDATA_WIDTH-1:0] rsp_tdata,  // [NUMBER_WIDTH-1:0] number_out
   output logic                             rsp_tuser   // [0] is_prime
);
   import tdpt_pkg::*;

   cmd_type                 cmd;
   status_type              status;
   logic [NUMBER_WIDTH-1:0] number_out;

   tdpt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tdpt_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .candidate  (req_tdata[NUMBER_WIDTH-1:0]),
      .status     (status),
      .number_out (number_out),
      .is_prime   (rsp_tuser)
   );

   assign rsp_tdata = TDATA_WIDTH'(number_out);

endmodule

[tb/trial_division_prime_checker.sv]
`timescale 1ns / 100ps
// Watches both channels of the prime test block, predicts each verdict and compares it.
module trial_division_prime_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [tdpt_pkg::TDATA_WIDTH-1:0] req_tdata,  // [NUMBER_WIDTH-1:0] candidate
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [tdpt_pkg::TDATA_WIDTH-1:0] rsp_tdata,  // [NUMBER_WIDTH-1:0] number_out
   input  logic                             rsp_tuser,  // [0] is_prime
   output int                               fail_count,
   output int                               pending_count
);

   import tdpt_pkg::*;

   typedef struct packed {
      logic [NUMBER_WIDTH-1:0] number;
      logic                    prime;
   } prime_verdict_type;

   prime_verdict_type expected_verdicts[$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic prime_verdict_type predict_verdict(input logic [NUMBER_WIDTH-1:0] n);
      prime_verdict_type verdict;
      longint unsigned   divisor;
      logic              factor;
      divisor = 2;
      factor  = 1'b0;
      if (n >= 2) begin
         // Only divisors up to the square root can be the smallest factor.
         while (divisor * divisor <= longint'(n)) begin
            if ((longint'(n) % divisor) == 0) begin
               factor = 1'b1;
               break;
            end
            divisor++;
         end
      end
      verdict.number = n;
      verdict.prime  = (n >= 2) && !factor;
      return verdict;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      prime_verdict_type want;
      if (!reset) begin
         // Pop before push, so a result never matches an item accepted in the same cycle.
         if (rsp_tvalid && rsp_tready) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch("unexpected result item, number_out", rsp_tdata, -1);
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_tdata !== TDATA_WIDTH'(want.number))
                  report_mismatch("number_out", rsp_tdata, want.number);
               if (rsp_tuser !== want.prime)
                  report_mismatch($sformatf("is_prime of %0d", want.number), rsp_tuser,
                                  want.prime);
            end
         end
         if (req_tvalid && req_tready)
            expected_verdicts.push_back(predict_verdict(req_tdata[NUMBER_WIDTH-1:0]));
         pending_count = expected_verdicts.size();
      end
   end

endmodule

[tb/tb_trial_division_prime_test.sv]
`timescale 1ns / 100ps
// Top of the prime test bench: clock, reset, candidate stimulus, result back-pressure, verdict.
module tb_trial_division_prime_test;

   import tdpt_pkg::*;

   localparam int LONG_HOLD_CYCLES = 3000;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [TDATA_WIDTH-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [TDATA_WIDTH-1:0] rsp_tdata;
   logic                   rsp_tuser;

   int fail_count;
   int pending_count;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_left;
   logic pressure_on;
   logic hold_started;

   logic [NUMBER_WIDTH-1:0] directed_candidates[] = '{
      0, 1, 2, 3, 4, 5, 6, 7, 9, 25, 49, 121, 127, 128, 255, 257,
      21845, 43690, 32768, 63001, 65025, 65521, 65535
   };

   trial_division_prime_test DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   trial_division_prime_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Offer one candidate; entered and left at a falling edge.
   task automatic send_candidate(input logic [NUMBER_WIDTH-1:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= TDATA_WIDTH'(value);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Most candidates are small so that the search stays short; some span the
   // full range and some sit just below the top, where the longest searches are.
   function automatic logic [NUMBER_WIDTH-1:0] random_candidate();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return NUMBER_WIDTH'($urandom_range(0, 1023));
      else if (pick < 90)
         return NUMBER_WIDTH'($urandom);
      else
         return {NUMBER_WIDTH{1'b1}} - NUMBER_WIDTH'($urandom_range(0, 300));
   endfunction

   task automatic run_random_phase(input int count, input int idle_pct, input int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) send_candidate(random_candidate());
   endtask

   // Result side: random stalls, plus one long hold-off once the pressure phase begins.
   initial begin
      rsp_tready   = 1'b0;
      hold_left    = 0;
      hold_started = 1'b0;
      forever begin
         @(negedge clock);
         if (pressure_on && !hold_started) begin
            hold_started = 1'b1;
            hold_left    = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      pressure_on    = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_candidates[i]) send_candidate(directed_candidates[i]);

      run_random_phase(26, 0, 0);
      run_random_phase(26, 74, 0);
      run_random_phase(26, 0, 74);
      run_random_phase(26, 12, 12);

      // The receiver holds off while small candidates keep arriving, so the
      // result register fills and the input side has to stall.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      pressure_on    = 1'b1;
      repeat (12) send_candidate(NUMBER_WIDTH'($urandom_range(0, 63)));

      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

[sim.f]
rtl/tdpt_pkg.sv
rtl/tdpt_dpath.sv
rtl/tdpt_ctrl.sv
rtl/trial_division_prime_test.sv
tb/trial_division_prime_checker.sv
tb/tb_trial_division_prime_test.sv
